// ----- hdl/pva_pkg.sv -----
// Shared constants, codes and types of the polyphonic voice allocator.
package pva_pkg;

    localparam int VOICES  = 8;
    localparam int NOTES   = 128;
    localparam int VOICE_W = $clog2(VOICES);
    localparam int NOTE_W  = $clog2(NOTES);
    localparam int VNOTE_W = NOTE_W + 1;
    localparam int VEL_W   = 7;
    localparam int DONE_W  = 3;
    localparam int REQ_W   = 2;
    localparam int ACT_W   = 2;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 8;

    // Stored voice note that no incoming note can ever equal.
    localparam logic [VNOTE_W-1:0] NO_NOTE = VNOTE_W'(NOTES);

    localparam logic [REQ_W-1:0] REQ_NOTE_ON    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_NOTE_OFF   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_VOICE_DONE = 2'd2;

    typedef enum logic [ACT_W-1:0] {
        ACT_START   = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_NOTHING = 2'd2,
        ACT_FREED   = 2'd3
    } t_action;

    typedef struct packed {
        logic               wr;
        logic [VOICE_W-1:0] idx;
        logic               set_note;
        logic [VNOTE_W-1:0] note;
        logic               active;
    } t_vt_wr;

    typedef struct packed {
        logic               match_found;
        logic [VOICE_W-1:0] match_idx;
        logic               free_found;
        logic [VOICE_W-1:0] free_idx;
        logic [VOICE_W-1:0] best_idx;
        logic [VOICE_W-1:0] sel;
    } t_scan_res;

endpackage

// ----- hdl/pva_ram.sv -----
// Generic simple dual-port RAM with registered read data.
module pva_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/pva_voice_table.sv -----
// Per-voice state: active flag and last assigned note.
module pva_voice_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [pva_pkg::VOICE_W-1:0]   i_rd_idx,
    output logic [pva_pkg::VNOTE_W-1:0]   o_rd_note,
    output logic                          o_rd_active,
    input  pva_pkg::t_vt_wr               i_wr
);

    logic [pva_pkg::VNOTE_W-1:0] r_note [pva_pkg::VOICES];
    logic [pva_pkg::VOICES-1:0]  r_active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
            for (int i = 0; i < pva_pkg::VOICES; i++) begin
                r_note[i] <= pva_pkg::NO_NOTE;
            end
        end else if (i_wr.wr) begin
            r_active[i_wr.idx] <= i_wr.active;
            if (i_wr.set_note) begin
                r_note[i_wr.idx] <= i_wr.note;
            end
        end
    end

    assign o_rd_note   = r_note[i_rd_idx];
    assign o_rd_active = r_active[i_rd_idx];

endmodule

// ----- hdl/pva_scan.sv -----
// Shared compare unit that visits one voice per cycle to pick a voice.
module pva_scan (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_clear,
    input  logic                          i_step,
    input  logic [pva_pkg::VOICE_W-1:0]   i_idx,
    input  logic [pva_pkg::VNOTE_W-1:0]   i_want,
    input  logic [pva_pkg::VNOTE_W-1:0]   i_note,
    input  logic                          i_active,
    output pva_pkg::t_scan_res            o_res
);

    logic                        r_match_found;
    logic [pva_pkg::VOICE_W-1:0] r_match_idx;
    logic                        r_free_found;
    logic [pva_pkg::VOICE_W-1:0] r_free_idx;
    logic [pva_pkg::VOICE_W-1:0] r_best_idx;
    logic [pva_pkg::VNOTE_W-1:0] r_best_note;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_match_found <= 1'b0;
            r_free_found  <= 1'b0;
            r_match_idx   <= '0;
            r_free_idx    <= '0;
            r_best_idx    <= '0;
            r_best_note   <= '0;
        end else if (i_step) begin
            // Only the first hit counts for match and free; the highest note
            // keeps the lowest index because the compare is strict.
            if (!r_match_found && i_note == i_want) begin
                r_match_found <= 1'b1;
                r_match_idx   <= i_idx;
            end
            if (!r_free_found && !i_active) begin
                r_free_found <= 1'b1;
                r_free_idx   <= i_idx;
            end
            if (i_note > r_best_note) begin
                r_best_note <= i_note;
                r_best_idx  <= i_idx;
            end
        end
    end

    always_comb begin
        o_res.match_found = r_match_found;
        o_res.match_idx   = r_match_idx;
        o_res.free_found  = r_free_found;
        o_res.free_idx    = r_free_idx;
        o_res.best_idx    = r_best_idx;
        priority if (r_match_found) begin
            o_res.sel = r_match_idx;
        end else if (r_free_found) begin
            o_res.sel = r_free_idx;
        end else begin
            o_res.sel = r_best_idx;
        end
    end

endmodule

// ----- hdl/poly_voice_allocator.sv -----
// Top level of the polyphonic voice allocator with voice stealing.
// A note-on with nonzero velocity takes one scan step per voice through the shared compare unit,
// then a commit step and an output-load step.
// A release goes through a note map RAM read and a check step, a voice-finished or unused event a free step.
// One result per event; it sits in an output register while the next event is taken.
// Synchronous active-low reset clears all voices, their notes and the note map valid bits.
module poly_voice_allocator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // note [6:0], velocity [13:7], done_voice [16:14], zero fill [23:17]
    input  logic [pva_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // req_type [1:0]
    input  logic [pva_pkg::REQ_W-1:0]       s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // voice [2:0], zero fill [7:3]
    output logic [pva_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // action [1:0]
    output logic [pva_pkg::ACT_W-1:0]       m_axis_tuser
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT,
        S_MAPRD,
        S_MAPCHK,
        S_FREE,
        S_OUT
    } t_state;

    t_state                       r_state;
    logic [pva_pkg::REQ_W-1:0]    r_req;
    logic [pva_pkg::NOTE_W-1:0]   r_note;
    logic [pva_pkg::DONE_W-1:0]   r_done;
    logic [pva_pkg::VOICE_W-1:0]  r_idx;
    logic                         r_map_hit;
    pva_pkg::t_action             r_act;
    logic [pva_pkg::VOICE_W-1:0]  r_voice;
    logic                         r_out_valid;
    pva_pkg::t_action             r_out_action;
    logic [pva_pkg::VOICE_W-1:0]  r_out_voice;
    logic [pva_pkg::NOTES-1:0]    r_map_vld;

    logic [pva_pkg::NOTE_W-1:0]   in_note;
    logic [pva_pkg::VEL_W-1:0]    in_vel;
    logic [pva_pkg::DONE_W-1:0]   in_done;
    logic                         accept;

    logic [pva_pkg::VOICE_W-1:0]  map_rdata;
    logic [pva_pkg::VOICE_W-1:0]  map_voice;
    logic                         map_we;
    logic [pva_pkg::VOICE_W-1:0]  vt_rd_idx;
    logic [pva_pkg::VNOTE_W-1:0]  vt_rd_note;
    logic                         vt_rd_active;
    pva_pkg::t_vt_wr              vt_wr;
    pva_pkg::t_scan_res           scan_res;

    assign in_note = s_axis_tdata[pva_pkg::NOTE_W-1:0];
    assign in_vel  = s_axis_tdata[pva_pkg::NOTE_W +: pva_pkg::VEL_W];
    assign in_done = s_axis_tdata[pva_pkg::NOTE_W + pva_pkg::VEL_W +: pva_pkg::DONE_W];

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // A note never written since reset maps to voice zero.
    assign map_voice = r_map_hit ? map_rdata : '0;
    assign map_we    = (r_state == S_COMMIT);

    always_comb begin
        vt_rd_idx = (r_state == S_MAPCHK) ? map_voice : r_idx;

        vt_wr          = '0;
        vt_wr.idx      = scan_res.sel;
        vt_wr.note     = {1'b0, r_note};
        if (r_state == S_COMMIT) begin
            vt_wr.wr       = 1'b1;
            vt_wr.set_note = 1'b1;
            vt_wr.active   = 1'b1;
        end else if (r_state == S_FREE && r_req == pva_pkg::REQ_VOICE_DONE
                     && int'(r_done) < pva_pkg::VOICES) begin
            vt_wr.wr     = 1'b1;
            vt_wr.idx    = pva_pkg::VOICE_W'(r_done);
            vt_wr.active = 1'b0;
        end
    end

    pva_ram #(
        .WIDTH (pva_pkg::VOICE_W),
        .DEPTH (pva_pkg::NOTES)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (r_note),
        .i_wdata (scan_res.sel),
        .i_raddr (r_note),
        .o_rdata (map_rdata)
    );

    pva_voice_table u_voice_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_idx    (vt_rd_idx),
        .o_rd_note   (vt_rd_note),
        .o_rd_active (vt_rd_active),
        .i_wr        (vt_wr)
    );

    pva_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (accept),
        .i_step   (r_state == S_SCAN),
        .i_idx    (r_idx),
        .i_want   ({1'b0, r_note}),
        .i_note   (vt_rd_note),
        .i_active (vt_rd_active),
        .o_res    (scan_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_map_vld   <= '0;
            r_idx       <= '0;
            r_map_hit   <= 1'b0;
        end else begin
            // In S_OUT the output load below decides the valid bit.
            if (m_axis_tready && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_req  <= s_axis_tuser;
                        r_note <= in_note;
                        r_done <= in_done;
                        r_idx  <= '0;
                        if (s_axis_tuser == pva_pkg::REQ_NOTE_ON && in_vel != '0) begin
                            r_state <= S_SCAN;
                        end else if (s_axis_tuser == pva_pkg::REQ_NOTE_ON
                                     || s_axis_tuser == pva_pkg::REQ_NOTE_OFF) begin
                            r_state <= S_MAPRD;
                        end else begin
                            r_state <= S_FREE;
                        end
                    end
                end
                S_SCAN: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == pva_pkg::VOICE_W'(pva_pkg::VOICES - 1)) begin
                        r_state <= S_COMMIT;
                    end
                end
                S_COMMIT: begin
                    r_map_vld[r_note] <= 1'b1;
                    r_act             <= pva_pkg::ACT_START;
                    r_voice           <= scan_res.sel;
                    r_state           <= S_OUT;
                end
                S_MAPRD: begin
                    r_map_hit <= r_map_vld[r_note];
                    r_state   <= S_MAPCHK;
                end
                S_MAPCHK: begin
                    // Velocity-zero note-on releases unconditionally.
                    if (r_req == pva_pkg::REQ_NOTE_ON
                        || (vt_rd_active && int'(map_voice) < pva_pkg::VOICES)) begin
                        r_act   <= pva_pkg::ACT_RELEASE;
                        r_voice <= map_voice;
                    end else begin
                        r_act   <= pva_pkg::ACT_NOTHING;
                        r_voice <= '0;
                    end
                    r_state <= S_OUT;
                end
                S_FREE: begin
                    if (r_req == pva_pkg::REQ_VOICE_DONE && int'(r_done) < pva_pkg::VOICES) begin
                        r_act   <= pva_pkg::ACT_FREED;
                        r_voice <= pva_pkg::VOICE_W'(r_done);
                    end else begin
                        r_act   <= pva_pkg::ACT_NOTHING;
                        r_voice <= '0;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid  <= 1'b1;
                        r_out_action <= r_act;
                        r_out_voice  <= r_voice;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = pva_pkg::OUT_DATA_W'(r_out_voice);
    assign m_axis_tuser  = r_out_action;

endmodule

// ----- hdl/pva_checker.sv -----
// Port-level checks of the voice allocator, bound to the top level.
module pva_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [pva_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input logic [pva_pkg::REQ_W-1:0]       s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [pva_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input logic [pva_pkg::ACT_W-1:0]       m_axis_tuser
);

    // Coming out of reset the block holds no result and takes an event.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("pva: bad state after reset");

    // After an input transfer the block is not ready again in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("pva: ready right after an input transfer");

    // A stalled result holds its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready
        |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("pva: stalled result changed");

    // An event with no effect always reports voice zero.
    a_nothing_voice_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == pva_pkg::ACT_W'(pva_pkg::ACT_NOTHING)
        |-> m_axis_tdata == '0)
        else $error("pva: no-op result with nonzero voice");

endmodule

bind poly_voice_allocator pva_checker u_pva_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ----- bench/poly_voice_allocator_test.sv -----
// Self-checking testbench for the polyphonic voice allocator, with its own voice table model.
`timescale 1ns / 1ps

module poly_voice_allocator_test;

    localparam logic [pva_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int RESET_CYCLES = 11;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 30;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_EVENTS = 200;

    typedef struct {
        logic [pva_pkg::REQ_W-1:0]  req;
        logic [pva_pkg::NOTE_W-1:0] note;
        logic [pva_pkg::VEL_W-1:0]  vel;
        logic [pva_pkg::DONE_W-1:0] done;
    } t_midi_event;

    typedef struct {
        pva_pkg::t_action            act;
        logic [pva_pkg::VOICE_W-1:0] voice;
    } t_voice_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [pva_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
    logic [pva_pkg::REQ_W-1:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [pva_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic [pva_pkg::ACT_W-1:0] m_axis_tuser;

    poly_voice_allocator DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_midi_event   midi_backlog[$];
    t_voice_result awaited_results[$];

    // Voice table as the allocator should hold it.
    logic                        voice_busy [pva_pkg::VOICES] = '{default: 1'b0};
    logic [pva_pkg::VNOTE_W-1:0] voice_held_note [pva_pkg::VOICES] =
        '{default: pva_pkg::NO_NOTE};
    logic [pva_pkg::VOICE_W-1:0] note_owner [pva_pkg::NOTES] = '{default: '0};

    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;
    int mismatches = 0;
    int cycle_count = 0;
    int events_sent = 0;
    int starts_seen = 0;
    int releases_seen = 0;
    int frees_seen = 0;
    int idles_seen = 0;
    logic in_taken = 1'b0;

    function automatic logic [pva_pkg::VOICE_W-1:0] choose_voice(
        input logic [pva_pkg::NOTE_W-1:0] note);
        logic [pva_pkg::VOICE_W-1:0] best;
        logic [pva_pkg::VNOTE_W-1:0] best_note;
        best = '0;
        best_note = '0;
        for (int i = 0; i < pva_pkg::VOICES; i++)
            if (voice_held_note[i] == {1'b0, note}) return pva_pkg::VOICE_W'(i);
        for (int i = 0; i < pva_pkg::VOICES; i++)
            if (!voice_busy[i]) return pva_pkg::VOICE_W'(i);
        // Every voice is sounding: steal the one on the highest note.
        for (int i = 0; i < pva_pkg::VOICES; i++) begin
            if (voice_held_note[i] > best_note) begin
                best_note = voice_held_note[i];
                best = pva_pkg::VOICE_W'(i);
            end
        end
        return best;
    endfunction

    function automatic t_voice_result allocate_event(input t_midi_event ev);
        t_voice_result res;
        logic [pva_pkg::VOICE_W-1:0] v;
        res.act = pva_pkg::ACT_NOTHING;
        res.voice = '0;
        case (ev.req)
            pva_pkg::REQ_NOTE_ON: begin
                if (ev.vel != '0) begin
                    v = choose_voice(ev.note);
                    note_owner[ev.note] = v;
                    voice_held_note[v] = {1'b0, ev.note};
                    voice_busy[v] = 1'b1;
                    res.act = pva_pkg::ACT_START;
                    res.voice = v;
                end else begin
                    res.act = pva_pkg::ACT_RELEASE;
                    res.voice = note_owner[ev.note];
                end
            end
            pva_pkg::REQ_NOTE_OFF: begin
                v = note_owner[ev.note];
                if (voice_busy[v]) begin
                    res.act = pva_pkg::ACT_RELEASE;
                    res.voice = v;
                end
            end
            pva_pkg::REQ_VOICE_DONE: begin
                if (int'(ev.done) < pva_pkg::VOICES) begin
                    voice_busy[ev.done] = 1'b0;
                    res.act = pva_pkg::ACT_FREED;
                    res.voice = pva_pkg::VOICE_W'(ev.done);
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Driver: a new event goes out once the previous transfer has completed.
    always @(negedge i_clk) begin
        t_midi_event ev;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            if (midi_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                ev = midi_backlog.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {7'd0, ev.done, ev.vel, ev.note};
                s_axis_tuser <= ev.req;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result side ready, with random stalls and one long hold-off.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (holds_served != hold_requests) begin
            holds_served <= hold_requests;
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // Monitor: checks each result transfer, then predicts for each accepted event.
    always @(posedge i_clk) begin
        t_voice_result want;
        t_midi_event ev;
        in_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                case (m_axis_tuser)
                    pva_pkg::ACT_START:   starts_seen++;
                    pva_pkg::ACT_RELEASE: releases_seen++;
                    pva_pkg::ACT_FREED:   frees_seen++;
                    default:              idles_seen++;
                endcase
                if (awaited_results.size() == 0) begin
                    $display("%0t: unexpected result action %0d voice %0d", $time,
                             m_axis_tuser, m_axis_tdata[pva_pkg::VOICE_W-1:0]);
                    mismatches++;
                end else begin
                    want = awaited_results.pop_front();
                    if (m_axis_tuser !== want.act) begin
                        $display("%0t: action mismatch, expected %0d actual %0d", $time,
                                 want.act, m_axis_tuser);
                        mismatches++;
                    end
                    if (m_axis_tdata[pva_pkg::VOICE_W-1:0] !== want.voice) begin
                        $display("%0t: voice mismatch, expected %0d actual %0d", $time,
                                 want.voice, m_axis_tdata[pva_pkg::VOICE_W-1:0]);
                        mismatches++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                ev.note = s_axis_tdata[6:0];
                ev.vel  = s_axis_tdata[13:7];
                ev.done = s_axis_tdata[16:14];
                ev.req  = s_axis_tuser;
                awaited_results.push_back(allocate_event(ev));
                events_sent++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     awaited_results.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic add_event(input logic [pva_pkg::REQ_W-1:0] req, input int note,
                             input int vel, input int done);
        t_midi_event ev;
        ev.req = req;
        ev.note = pva_pkg::NOTE_W'(note);
        ev.vel = pva_pkg::VEL_W'(vel);
        ev.done = pva_pkg::DONE_W'(done);
        midi_backlog.push_back(ev);
    endtask

    // Mostly notes from a narrow range so that voices get reused and stolen.
    function automatic int pick_note();
        if ($urandom_range(99) < 70) return $urandom_range(71, 48);
        return $urandom_range(pva_pkg::NOTES - 1);
    endfunction

    task automatic add_random_events(input int count);
        int kind;
        int vel;
        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(99);
            vel = ($urandom_range(9) == 0) ? 0 : $urandom_range(127, 1);
            if (kind < 50)
                add_event(pva_pkg::REQ_NOTE_ON, pick_note(), vel, $urandom_range(7));
            else if (kind < 75)
                add_event(pva_pkg::REQ_NOTE_OFF, pick_note(), $urandom_range(127),
                          $urandom_range(7));
            else if (kind < 94)
                add_event(pva_pkg::REQ_VOICE_DONE, $urandom_range(127), $urandom_range(127),
                          $urandom_range(pva_pkg::VOICES - 1));
            else
                add_event(REQ_UNUSED, $urandom_range(127), $urandom_range(127),
                          $urandom_range(7));
        end
    endtask

    task automatic wait_drained();
        do begin
            @(posedge i_clk);
            #1;
        end while (midi_backlog.size() != 0 || s_axis_tvalid || awaited_results.size() != 0);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, run with no idling while the result side holds off at first.
        add_event(pva_pkg::REQ_NOTE_ON, 0, 127, 0);
        add_event(pva_pkg::REQ_NOTE_ON, 127, 1, 7);
        add_event(pva_pkg::REQ_NOTE_OFF, 127, 0, 0);
        add_event(pva_pkg::REQ_VOICE_DONE, 0, 0, 0);
        // Note-off whose voice has gone idle, then freeing a voice that is already free.
        add_event(pva_pkg::REQ_NOTE_OFF, 0, 127, 0);
        add_event(pva_pkg::REQ_VOICE_DONE, 0, 0, 0);
        // A freed voice keeps its note, so the same note lands on it again.
        add_event(pva_pkg::REQ_NOTE_ON, 0, 64, 0);
        add_event(pva_pkg::REQ_NOTE_ON, 85, 42, 5);
        add_event(pva_pkg::REQ_NOTE_ON, 42, 85, 2);
        for (int i = 0; i < 4; i++)
            add_event(pva_pkg::REQ_NOTE_ON, 60 + i, 100, 0);
        // All voices sound now: the highest note is stolen twice in a row.
        add_event(pva_pkg::REQ_NOTE_ON, 100, 10, 0);
        add_event(pva_pkg::REQ_NOTE_ON, 127, 20, 0);
        // Velocity zero releases the mapped voice even for a note never played.
        add_event(pva_pkg::REQ_NOTE_ON, 50, 0, 0);
        add_event(pva_pkg::REQ_NOTE_ON, 62, 0, 0);
        add_event(pva_pkg::REQ_VOICE_DONE, 0, 0, 7);
        add_event(pva_pkg::REQ_NOTE_ON, 33, 33, 0);
        add_event(REQ_UNUSED, 127, 127, 7);
        add_event(pva_pkg::REQ_NOTE_OFF, 60, 1, 0);
        add_event(pva_pkg::REQ_VOICE_DONE, 127, 127, 4);
        add_event(pva_pkg::REQ_VOICE_DONE, 0, 0, 3);
        add_event(pva_pkg::REQ_NOTE_OFF, 42, 0, 0);
        hold_requests = hold_requests + 1;
        add_random_events(PHASE_EVENTS);
        wait_drained();

        src_idle_pct = 80;
        add_random_events(PHASE_EVENTS);
        wait_drained();

        src_idle_pct = 0;
        snk_stall_pct = 80;
        add_random_events(PHASE_EVENTS);
        wait_drained();

        src_idle_pct = 9;
        snk_stall_pct = 9;
        add_random_events(PHASE_EVENTS);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (awaited_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, awaited_results.size());
            mismatches++;
        end
        $display("Sent %0d note events through four idle patterns and one long output stall.",
                 events_sent);
        $display("Results seen: %0d starts, %0d releases, %0d frees, %0d no-ops; %0d errors.",
                 starts_seen, releases_seen, frees_seen, idles_seen, mismatches);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
